/* hw/rtl/gnno_pkg.sv */
// ----------------------------------------------------------------------------
// gnno_pkg
// Shared types and constants for the greedy nearest-neighbor ordering block.
// ----------------------------------------------------------------------------
package gnno_pkg;

    localparam int COORD_W = 20;
    localparam int ID_W    = 6;
    localparam int POS_W   = 6;
    localparam int ABS_W   = COORD_W + 1;
    localparam int SQ_W    = 2 * ABS_W;
    localparam int SUM_W   = SQ_W + 2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [ABS_W-1:0]          absd_t;
    typedef logic [SQ_W-1:0]           sq_t;
    typedef logic [SUM_W-1:0]          dist_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } coord3_t;

    // input request
    typedef struct packed {
        logic [ID_W-1:0] boson_id;
        coord_t          pos_x;
        coord_t          pos_y;
        coord_t          pos_z;
        coord_t          next_x;
        coord_t          next_y;
        coord_t          next_z;
        logic            last;
    } item_t;

    // output request
    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [ID_W-1:0]  boson_id_res;
        logic             last_res;
    } order_t;

    // one particle as held in a cell
    typedef struct packed {
        logic [ID_W-1:0] id;
        coord3_t         pos;
        coord3_t         nxt;
    } particle_t;

    typedef struct packed {
        particle_t p;
        logic      valid;
        logic      taken;
    } cell_t;

    // |a - b| of two signed coordinates, exact
    function automatic absd_t abs_diff(coord_t a, coord_t b);
        logic signed [ABS_W-1:0] d;
        absd_t                   r;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        r = d[ABS_W-1] ? (~d + 1'b1) : d;
        return r;
    endfunction

endpackage

/* hw/rtl/gnno_cell.sv */
// ----------------------------------------------------------------------------
// gnno_cell
// One ring cell: holds one particle with its valid and taken flags.
// ----------------------------------------------------------------------------
module gnno_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clear,
    input  logic               load_en,
    input  gnno_pkg::particle_t load_data,
    input  logic               shift_en,
    input  gnno_pkg::cell_t    shift_in,
    input  logic               set_taken,
    output gnno_pkg::cell_t    state
);
    import gnno_pkg::*;

    logic      valid_reg;
    logic      taken_reg;
    particle_t p_reg;

    // flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            taken_reg <= 1'b0;
        end
        else if (clear)
        begin
            valid_reg <= 1'b0;
            taken_reg <= 1'b0;
        end
        else if (load_en)
        begin
            valid_reg <= 1'b1;
            taken_reg <= 1'b0;
        end
        else if (shift_en)
        begin
            valid_reg <= shift_in.valid;
            taken_reg <= shift_in.taken;
        end
        else if (set_taken)
        begin
            taken_reg <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            p_reg <= load_data;
        end
        else if (shift_en)
        begin
            p_reg <= shift_in.p;
        end
    end

    assign state.p     = p_reg;
    assign state.valid = valid_reg;
    assign state.taken = taken_reg;

endmodule

/* hw/rtl/gnno_dist.sv */
// ----------------------------------------------------------------------------
// gnno_dist
// Three-stage squared distance unit: abs diff, square, sum. Tags ride along.
// ----------------------------------------------------------------------------
module gnno_dist #(
    parameter int DIMS  = 3,
    parameter int IDX_W = 6
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      feed_vld,
    input  logic [IDX_W-1:0]          feed_slot,
    input  gnno_pkg::particle_t       feed_p,
    input  gnno_pkg::coord3_t         cur_pos,
    output logic                      d_vld,
    output gnno_pkg::dist_t           d_val,
    output logic [IDX_W-1:0]          d_slot,
    output logic [gnno_pkg::ID_W-1:0] d_id,
    output gnno_pkg::coord3_t         d_pos
);
    import gnno_pkg::*;

    logic             vld_reg [3];
    logic [IDX_W-1:0] slot_reg [3];
    logic [ID_W-1:0]  id_reg [3];
    coord3_t          pos_reg [3];
    absd_t            ad_reg [3];
    sq_t              sq_reg [3];
    dist_t            sum_reg;
    absd_t            ad_next [3];

    // per-axis difference, unused axes forced to zero
    always_comb
    begin
        ad_next[0] = abs_diff(cur_pos.x, feed_p.nxt.x);
        ad_next[1] = (DIMS > 1) ? abs_diff(cur_pos.y, feed_p.nxt.y) : '0;
        ad_next[2] = (DIMS > 2) ? abs_diff(cur_pos.z, feed_p.nxt.z) : '0;
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
            vld_reg[1] <= 1'b0;
            vld_reg[2] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= feed_vld;
            vld_reg[1] <= vld_reg[0];
            vld_reg[2] <= vld_reg[1];
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        slot_reg[0] <= feed_slot;
        id_reg[0]   <= feed_p.id;
        pos_reg[0]  <= feed_p.pos;
        for (int a = 0; a < 3; a++)
        begin
            ad_reg[a] <= ad_next[a];
            sq_reg[a] <= ad_reg[a] * ad_reg[a];
        end
        slot_reg[1] <= slot_reg[0];
        id_reg[1]   <= id_reg[0];
        pos_reg[1]  <= pos_reg[0];
        sum_reg     <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
        slot_reg[2] <= slot_reg[1];
        id_reg[2]   <= id_reg[1];
        pos_reg[2]  <= pos_reg[1];
    end

    assign d_vld  = vld_reg[2];
    assign d_val  = sum_reg;
    assign d_slot = slot_reg[2];
    assign d_id   = id_reg[2];
    assign d_pos  = pos_reg[2];

endmodule

/* hw/rtl/greedy_nearest_neighbor_order.sv */
// ----------------------------------------------------------------------------
// greedy_nearest_neighbor_order
// Loads a particle set into a ring of cells, then builds a greedy
// nearest-neighbor order by rotating the ring past one distance unit.
// ----------------------------------------------------------------------------
//  channel | valid        | stall        | payload
//  in      | item_valid   | item_stall   | item  (gnno_pkg::item_t)
//  out     | order_valid  | order_stall  | order (gnno_pkg::order_t)
//
//  Loading accepts one particle per cycle. After the last flag, place 0 is
//  issued from the ring head; each further place then takes one full ring
//  rotation feeding the distance unit, a drain of that unit, and a pick.
//  Input is stalled from the last flag until the final place is issued.
//  Output stalls only delay issue. Reset clears all cell flags.
// ----------------------------------------------------------------------------
module greedy_nearest_neighbor_order #(
    parameter int MAX_BOSONS = 64,
    parameter int DIMS       = 3
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  gnno_pkg::item_t  item,
    output logic             order_valid,
    input  logic             order_stall,
    output gnno_pkg::order_t order
);
    import gnno_pkg::*;

    localparam int IDX_W = (MAX_BOSONS > 1) ? $clog2(MAX_BOSONS) : 1;
    localparam int CNT_W = $clog2(MAX_BOSONS + 1);

    typedef enum logic [2:0] {
        S_LOAD,
        S_FIRST,
        S_SCAN,
        S_DRAIN,
        S_PICK
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] k_reg;
    logic [IDX_W-1:0] scan_reg;
    logic [1:0]       drain_reg;
    logic             out_valid_reg;
    order_t           out_reg;
    coord3_t          cur_reg;

    logic             found_reg;
    dist_t            best_d_reg;
    logic [IDX_W-1:0] best_slot_reg;
    logic [ID_W-1:0]  best_id_reg;
    coord3_t          best_pos_reg;

    cell_t            cells [MAX_BOSONS];
    particle_t        load_p;
    logic             accept;
    logic             cnt_full;
    logic             out_free;
    logic             shift_en;
    logic             clear_en;
    logic             taken_first;
    logic             taken_pick;
    logic             last_pick;

    logic             d_vld;
    dist_t            d_val;
    logic [IDX_W-1:0] d_slot;
    logic [ID_W-1:0]  d_id;
    coord3_t          d_pos;

    assign item_stall  = (state_reg != S_LOAD);
    assign accept      = item_valid && !item_stall;
    assign cnt_full    = (cnt_reg == CNT_W'(MAX_BOSONS));
    assign out_free    = !out_valid_reg || !order_stall;
    assign shift_en    = (state_reg == S_SCAN);
    assign last_pick   = (CNT_W'(k_reg + CNT_W'(1)) == n_reg);
    assign taken_first = (state_reg == S_FIRST) && out_free;
    assign taken_pick  = (state_reg == S_PICK) && out_free;
    assign clear_en    = (taken_first && (n_reg == CNT_W'(1)))
                       || (taken_pick && last_pick);

    assign load_p.id    = item.boson_id;
    assign load_p.pos.x = item.pos_x;
    assign load_p.pos.y = item.pos_y;
    assign load_p.pos.z = item.pos_z;
    assign load_p.nxt.x = item.next_x;
    assign load_p.nxt.y = item.next_y;
    assign load_p.nxt.z = item.next_z;

    // ring of cells, cell 0 is the head
    for (genvar i = 0; i < MAX_BOSONS; i++)
    begin : g_cell
        gnno_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .clear     (clear_en),
            .load_en   (accept && !cnt_full && (cnt_reg == CNT_W'(i))),
            .load_data (load_p),
            .shift_en  (shift_en),
            .shift_in  (cells[(i + 1) % MAX_BOSONS]),
            .set_taken ((taken_first && (i == 0))
                        || (taken_pick && (best_slot_reg == IDX_W'(i)))),
            .state     (cells[i])
        );
    end

    // distance unit fed from the ring head
    gnno_dist #(
        .DIMS  (DIMS),
        .IDX_W (IDX_W)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .feed_vld  (shift_en && cells[0].valid && !cells[0].taken),
        .feed_slot (scan_reg),
        .feed_p    (cells[0].p),
        .cur_pos   (cur_reg),
        .d_vld     (d_vld),
        .d_val     (d_val),
        .d_slot    (d_slot),
        .d_id      (d_id),
        .d_pos     (d_pos)
    );

    // running minimum, earlier slot wins ties
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (taken_first || taken_pick)
        begin
            found_reg <= 1'b0;
        end
        else if (d_vld && (!found_reg || (d_val < best_d_reg)))
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_vld && (!found_reg || (d_val < best_d_reg)))
        begin
            best_d_reg    <= d_val;
            best_slot_reg <= d_slot;
            best_id_reg   <= d_id;
            best_pos_reg  <= d_pos;
        end
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            cnt_reg       <= '0;
            n_reg         <= '0;
            k_reg         <= '0;
            scan_reg      <= '0;
            drain_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !order_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_LOAD:
                begin
                    if (accept)
                    begin
                        if (item.last)
                        begin
                            n_reg     <= cnt_full ? cnt_reg : CNT_W'(cnt_reg + CNT_W'(1));
                            state_reg <= S_FIRST;
                        end
                        if (!cnt_full)
                        begin
                            cnt_reg <= CNT_W'(cnt_reg + CNT_W'(1));
                        end
                    end
                end
                S_FIRST:
                begin
                    if (out_free)
                    begin
                        out_valid_reg         <= 1'b1;
                        out_reg.position      <= '0;
                        out_reg.boson_id_res  <= cells[0].p.id;
                        out_reg.last_res      <= (n_reg == CNT_W'(1));
                        cur_reg               <= cells[0].p.pos;
                        k_reg                 <= CNT_W'(1);
                        scan_reg              <= '0;
                        if (n_reg == CNT_W'(1))
                        begin
                            cnt_reg   <= '0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    scan_reg <= IDX_W'(scan_reg + IDX_W'(1));
                    if (scan_reg == IDX_W'(MAX_BOSONS - 1))
                    begin
                        drain_reg <= '0;
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    drain_reg <= drain_reg + 2'd1;
                    if (drain_reg == 2'd2)
                    begin
                        state_reg <= S_PICK;
                    end
                end
                S_PICK:
                begin
                    if (out_free)
                    begin
                        out_valid_reg        <= 1'b1;
                        out_reg.position     <= POS_W'(k_reg);
                        out_reg.boson_id_res <= best_id_reg;
                        out_reg.last_res     <= last_pick;
                        cur_reg              <= best_pos_reg;
                        k_reg                <= CNT_W'(k_reg + CNT_W'(1));
                        scan_reg             <= '0;
                        if (last_pick)
                        begin
                            cnt_reg   <= '0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign order_valid = out_valid_reg;
    assign order       = out_reg;

endmodule
